### design/mtrg_pkg.sv
// ----------------------------------------------------------------------------
// mtrg_pkg
// Shared constants, types and functions for the MT19937 random generator.
// ----------------------------------------------------------------------------
package mtrg_pkg;

   localparam int STATE_DEPTH   = 624;
   localparam int MIDDLE_OFFSET = 397;
   localparam int ADDR_W        = $clog2(STATE_DEPTH);
   localparam int POS_W         = $clog2(STATE_DEPTH + 2);
   localparam int WORD_W        = 32;
   localparam int RAND_W        = 31;

   localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
   localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd5489;
   localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908B0DF;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC60000;

   localparam logic [ADDR_W-1:0] LAST_INDEX  = ADDR_W'(STATE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] MID_OFFSET  = ADDR_W'(MIDDLE_OFFSET);
   localparam logic [ADDR_W-1:0] MID_WRAP    = ADDR_W'(STATE_DEPTH - MIDDLE_OFFSET);
   localparam logic [POS_W-1:0]  POS_TWIST   = POS_W'(STATE_DEPTH);
   localparam logic [POS_W-1:0]  POS_UNSEEDED = POS_W'(STATE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_PRIME,
      ST_TWIST,
      ST_READ,
      ST_LOAD
   } ctrl_state_type;

   typedef struct packed {
      logic seed_load;
      logic seed_step;
      logic twist_prime;
      logic twist_step;
      logic read_issue;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need_seed;
      logic need_twist;
      logic cnt_last;
      logic out_free;
   } status_type;

   function automatic logic [WORD_W-1:0] seed_next(input logic [WORD_W-1:0] x,
                                                   input logic [ADDR_W-1:0] k);
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] p;
      t = x ^ (x >> 30);
      p = WORD_W'(t * SEED_MULT);
      return p + WORD_W'(k) + WORD_W'(1);
   endfunction

   function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                    input logic [WORD_W-1:0] nxt,
                                                    input logic [WORD_W-1:0] mid);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] v;
      y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
      v = mid ^ (y >> 1);
      if (nxt[0]) begin
         v = v ^ TWIST_MATRIX;
      end
      return v;
   endfunction

   function automatic logic [RAND_W-1:0] temper(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] e;
      e = w;
      e = e ^ (e >> 11);
      e = e ^ ((e << 7) & TEMPER_B);
      e = e ^ ((e << 15) & TEMPER_C);
      e = e ^ (e >> 18);
      return e[RAND_W-1:0];
   endfunction

endpackage

### design/mtrg_datapath.sv
// ----------------------------------------------------------------------------
// mtrg_datapath
// State memory, seeding recurrence, twist pipeline, tempering and result
// register.
// ----------------------------------------------------------------------------
module mtrg_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  mtrg_pkg::cmd_type               cmd,
   output mtrg_pkg::status_type            sts,
   input  logic                            csr_valid,
   input  logic [mtrg_pkg::WORD_W-1:0]     csr_seed_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mtrg_pkg::RAND_W-1:0]     rsp_random_value
);

   logic [mtrg_pkg::WORD_W-1:0] mem [0:mtrg_pkg::STATE_DEPTH-1];

   logic [mtrg_pkg::WORD_W-1:0] seed_ff;
   logic [mtrg_pkg::WORD_W-1:0] x_ff;
   logic [mtrg_pkg::WORD_W-1:0] x_in;
   logic [mtrg_pkg::ADDR_W-1:0] cnt_ff;
   logic [mtrg_pkg::POS_W-1:0]  pos_ff;
   logic [mtrg_pkg::WORD_W-1:0] rd_a_ff;
   logic [mtrg_pkg::WORD_W-1:0] rd_b_ff;
   logic [mtrg_pkg::WORD_W-1:0] cur_ff;
   logic                        prime_pend_ff;
   logic                        wr_pend_ff;
   logic [mtrg_pkg::ADDR_W-1:0] tw_idx_ff;
   logic                        rsp_valid_ff;
   logic [mtrg_pkg::RAND_W-1:0] rsp_data_ff;

   logic [mtrg_pkg::ADDR_W-1:0] nxt_addr;
   logic [mtrg_pkg::ADDR_W-1:0] mid_addr;
   logic [mtrg_pkg::ADDR_W-1:0] rd_a_addr;
   logic                        rd_a_en;
   logic                        wr_en;
   logic [mtrg_pkg::ADDR_W-1:0] wr_addr;
   logic [mtrg_pkg::WORD_W-1:0] wr_data;

   always_comb begin
      nxt_addr = (cnt_ff == mtrg_pkg::LAST_INDEX) ? '0 : cnt_ff + 1'b1;
      mid_addr = (cnt_ff < mtrg_pkg::MID_WRAP) ? cnt_ff + mtrg_pkg::MID_OFFSET
                                               : cnt_ff - mtrg_pkg::MID_WRAP;
      rd_a_en  = cmd.twist_prime | cmd.twist_step | cmd.read_issue;
      if (cmd.twist_prime) begin
         rd_a_addr = '0;
      end else if (cmd.twist_step) begin
         rd_a_addr = nxt_addr;
      end else begin
         rd_a_addr = pos_ff[mtrg_pkg::ADDR_W-1:0];
      end
      wr_en   = cmd.seed_step | wr_pend_ff;
      wr_addr = cmd.seed_step ? cnt_ff : tw_idx_ff;
      wr_data = cmd.seed_step ? x_ff : mtrg_pkg::twist_word(cur_ff, rd_a_ff, rd_b_ff);
      x_in    = mtrg_pkg::seed_next(x_ff, cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (cmd.twist_step) begin
         rd_b_ff <= mem[mid_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_load) begin
         x_ff <= seed_ff;
      end else if (cmd.seed_step) begin
         x_ff <= x_in;
      end
      if (prime_pend_ff || wr_pend_ff) begin
         cur_ff <= rd_a_ff;
      end
      if (cmd.twist_step) begin
         tw_idx_ff <= cnt_ff;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= mtrg_pkg::temper(rd_a_ff);
      end
      if (cmd.seed_load || cmd.twist_prime) begin
         cnt_ff <= '0;
      end else if (cmd.seed_step || cmd.twist_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= mtrg_pkg::SEED_DEFAULT;
         pos_ff        <= mtrg_pkg::POS_UNSEEDED;
         prime_pend_ff <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_seed_value;
         end
         if (cmd.twist_step && (cnt_ff == mtrg_pkg::LAST_INDEX)) begin
            pos_ff <= '0;
         end else if (cmd.read_issue) begin
            pos_ff <= pos_ff + 1'b1;
         end
         prime_pend_ff <= cmd.twist_prime;
         wr_pend_ff    <= cmd.twist_step;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.need_seed  = pos_ff > mtrg_pkg::POS_TWIST;
      sts.need_twist = pos_ff == mtrg_pkg::POS_TWIST;
      sts.cnt_last   = cnt_ff == mtrg_pkg::LAST_INDEX;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_data_ff;

endmodule

### design/mtrg_controller.sv
// ----------------------------------------------------------------------------
// mtrg_controller
// Sequencer for seeding, twisting and drawing one word per request.
// ----------------------------------------------------------------------------
module mtrg_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_restart,
   input  mtrg_pkg::status_type sts,
   output mtrg_pkg::cmd_type    cmd
);

   mtrg_pkg::ctrl_state_type state_ff;
   mtrg_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtrg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mtrg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart || sts.need_seed) begin
                  cmd.seed_load = 1'b1;
                  state_in      = mtrg_pkg::ST_SEED;
               end else if (sts.need_twist) begin
                  state_in = mtrg_pkg::ST_PRIME;
               end else begin
                  cmd.read_issue = 1'b1;
                  state_in       = mtrg_pkg::ST_LOAD;
               end
            end
         end
         mtrg_pkg::ST_SEED: begin
            cmd.seed_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = mtrg_pkg::ST_PRIME;
            end
         end
         mtrg_pkg::ST_PRIME: begin
            cmd.twist_prime = 1'b1;
            state_in        = mtrg_pkg::ST_TWIST;
         end
         mtrg_pkg::ST_TWIST: begin
            cmd.twist_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = mtrg_pkg::ST_READ;
            end
         end
         mtrg_pkg::ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = mtrg_pkg::ST_LOAD;
         end
         mtrg_pkg::ST_LOAD: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = mtrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtrg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### design/mt19937_random_generator_top.sv
// ----------------------------------------------------------------------------
// mt19937_random_generator_top
// One request is in work at a time: a new one is taken only once the last result is loaded.
// Every 624th draw first runs a twist pass (two reads, one write a cycle).
// A restart, and the first request after reset, first seed all 624 state words
// and then run a twist pass.
// Reset is synchronous; it restores the default seed and marks state unseeded.
// ----------------------------------------------------------------------------
module mt19937_random_generator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mtrg_pkg::RAND_W-1:0]     rsp_random_value,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mtrg_pkg::WORD_W-1:0]     csr_seed_value
);

   mtrg_pkg::cmd_type    cmd;
   mtrg_pkg::status_type sts;

   assign csr_ready = 1'b1;

   mtrg_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .sts         (sts),
      .cmd         (cmd)
   );

   mtrg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid),
      .csr_seed_value   (csr_seed_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value)
   );

endmodule

### design/mtrg_checker.sv
// ----------------------------------------------------------------------------
// mtrg_checker
// Port-level checks on the generator's request and result transfers.
// ----------------------------------------------------------------------------
module mtrg_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mtrg_pkg::RAND_W-1:0] rsp_random_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_random_value))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared one cycle after request");

endmodule

bind mt19937_random_generator_top mtrg_checker u_mtrg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_random_value (rsp_random_value)
);

### verif/mt19937_random_generator_top_tb.sv
// ----------------------------------------------------------------------------
// mt19937_random_generator_top_tb
// Self-checking bench for the MT19937 generator. A queue of request items is
// driven in bursts while the response side stalls on its own pattern. Each
// accepted request is run through a local model of the seeding, twist and
// temper steps. Every response transfer is checked against the oldest
// predicted word. The seed register is rewritten between phases,
// extremes included.
// ----------------------------------------------------------------------------
module mt19937_random_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [mtrg_pkg::RAND_W-1:0]   rsp_random_value;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [mtrg_pkg::WORD_W-1:0]   csr_seed_value = '0;

   bit                            pending_restarts[$];
   logic [mtrg_pkg::RAND_W-1:0]   expected_randoms[$];
   int                            mismatch_count = 0;

   logic [mtrg_pkg::WORD_W-1:0]   mt_words [mtrg_pkg::STATE_DEPTH];
   int unsigned                   mt_pos = mtrg_pkg::STATE_DEPTH + 1;
   logic [mtrg_pkg::WORD_W-1:0]   mt_seed = 32'd5489;

   int                            burst_left = 0;
   int                            gap_left = 0;

   int                            stall_mode = 0;
   int                            mode_left = 0;
   int                            hold_left = 0;
   int                            responses_seen = 0;
   int                            next_hold_at = 400;

   mt19937_random_generator_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_seed_value   (csr_seed_value)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void seed_words();
      logic [mtrg_pkg::WORD_W-1:0] x;
      x = mt_seed;
      for (int k = 0; k < mtrg_pkg::STATE_DEPTH; k++) begin
         mt_words[k] = x;
         x = 32'd1812433253 * (x ^ (x >> 30)) + 32'(k + 1);
      end
   endfunction

   function automatic void twist_words();
      int                          nxt;
      int                          mid;
      logic [mtrg_pkg::WORD_W-1:0] y;
      logic [mtrg_pkg::WORD_W-1:0] v;
      for (int k = 0; k < mtrg_pkg::STATE_DEPTH; k++) begin
         nxt = (k + 1) % mtrg_pkg::STATE_DEPTH;
         mid = (k + mtrg_pkg::MIDDLE_OFFSET) % mtrg_pkg::STATE_DEPTH;
         y = {mt_words[k][31], mt_words[nxt][30:0]};
         v = mt_words[mid] ^ (y >> 1);
         if (mt_words[nxt][0]) begin
            v = v ^ 32'h9908B0DF;
         end
         mt_words[k] = v;
      end
   endfunction

   function automatic logic [mtrg_pkg::RAND_W-1:0] draw_random(input bit restart);
      logic [mtrg_pkg::WORD_W-1:0] e;
      if (restart || mt_pos > mtrg_pkg::STATE_DEPTH) begin
         seed_words();
         mt_pos = mtrg_pkg::STATE_DEPTH;
      end
      if (mt_pos >= mtrg_pkg::STATE_DEPTH) begin
         twist_words();
         mt_pos = 0;
      end
      e = mt_words[mt_pos];
      mt_pos++;
      e = e ^ (e >> 11);
      e = e ^ ((e << 7) & 32'h9D2C5680);
      e = e ^ ((e << 15) & 32'hEFC60000);
      e = e ^ (e >> 18);
      return e[mtrg_pkg::RAND_W-1:0];
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [mtrg_pkg::RAND_W-1:0] want,
                                  input logic [mtrg_pkg::RAND_W-1:0] got);
      $display("%0t mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_restarts.size() != 0 || req_valid || expected_randoms.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_seed(input logic [mtrg_pkg::WORD_W-1:0] value);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_seed_value <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      mt_seed = value;
      @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_randoms.push_back(draw_random(req_restart));
            void'(pending_restarts.pop_front());
            if (burst_left > 0) begin
               burst_left--;
            end
         end
         if (burst_left == 0 && gap_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
               burst_left = 150;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = $urandom_range(0, 6);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_restarts.size() != 0) begin
            req_valid   <= 1'b1;
            req_restart <= pending_restarts[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern, with a long hold-off now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
         end
         if (responses_seen >= next_hold_at) begin
            hold_left = 300;
            next_hold_at += 700;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(16, 128);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic [mtrg_pkg::RAND_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_randoms.size() == 0) begin
            report_mismatch("unexpected transfer", '0, rsp_random_value);
         end else begin
            want = expected_randoms.pop_front();
            if (rsp_random_value !== want) begin
               report_mismatch("random_value", want, rsp_random_value);
            end
         end
      end
   end

   initial begin
      #4ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [mtrg_pkg::WORD_W-1:0] phase_seeds [6];
      int                          count;
      phase_seeds[0] = $urandom();
      phase_seeds[1] = 32'hFFFFFFFF;
      phase_seeds[2] = 32'd5489;
      phase_seeds[3] = $urandom();
      phase_seeds[4] = 32'h80000000;
      phase_seeds[5] = $urandom();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default seed: first request seeds, then restarts back to back
      pending_restarts = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
      wait_idle();
      write_seed(32'h00000000);
      pending_restarts = '{1'b1, 1'b0, 1'b0};
      wait_idle();
      // a write alone must not reseed
      write_seed(32'hFFFFFFFF);
      pending_restarts = '{1'b0, 1'b1, 1'b0};
      wait_idle();
      write_seed(32'h00000001);
      pending_restarts = '{1'b1, 1'b0};
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         write_seed(phase_seeds[p]);
         count = (p == 2) ? 700 : $urandom_range(150, 250);
         pending_restarts.push_back(1'($urandom_range(0, 1)));
         for (int i = 1; i < count; i++) begin
            pending_restarts.push_back($urandom_range(0, 149) == 0);
         end
         wait_idle();
      end

      repeat (1300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### mt19937_random_generator_top.f
design/mtrg_pkg.sv
design/mtrg_datapath.sv
design/mtrg_controller.sv
design/mt19937_random_generator_top.sv
design/mtrg_checker.sv
verif/mt19937_random_generator_top_tb.sv
